FILE: sv/nlv_pkg.sv
// Shared types and constants for the numeric literal validator.
package nlv_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned MAXD_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_W    = 16;

  localparam logic [CHAR_W-1:0]  CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0]  CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0]  CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  CH_E     = 8'h65;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

  typedef enum logic [0:0] {
    FMT_REAL = 1'b0,
    FMT_INT  = 1'b1
  } fmt_t;

  typedef enum logic [0:0] {
    CFG_NUMBER_FORMAT = 1'b0,
    CFG_MAX_DIGITS    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_INT_PART = 3'd1,
    PH_FRACTION = 3'd2,
    PH_EXP_MARK = 3'd3,
    PH_EXP_SIGN = 3'd4,
    PH_EXP_DIGS = 3'd5
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_REAL  = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_NO_DIGITS = 3'd3,
    ST_BAD_SYM   = 3'd4
  } status_t;

  typedef struct packed {
    phase_t             phase;
    logic               mant_seen;
    logic               exp_seen;
    status_t            err;
    logic [COUNT_W-1:0] count;
    logic               stopped;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:     PH_START,
    mant_seen: 1'b0,
    exp_seen:  1'b0,
    err:       ST_OK,
    count:     '0,
    stopped:   1'b0
  };

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } verdict_t;

endpackage

FILE: sv/nlv_parser.sv
// Per-string parse state, character update and end-of-string verdict.
module nlv_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          end_i,
  input  logic [nlv_pkg::CHAR_W-1:0]    char_i,
  input  nlv_pkg::fmt_t                 fmt_i,
  input  logic [nlv_pkg::MAXD_W-1:0]    max_digits_i,
  output nlv_pkg::verdict_t             verdict_o
);

  nlv_pkg::parse_state_t st_r;
  nlv_pkg::parse_state_t st_nxt;
  nlv_pkg::parse_state_t ch_st;
  logic                  dig;
  logic                  sgn;
  logic [nlv_pkg::COUNT_W-1:0] cnt_inc;
  nlv_pkg::status_t      st_code;
  logic                  too_many;

  assign dig = (char_i >= nlv_pkg::CH_ZERO) && (char_i <= nlv_pkg::CH_NINE);
  assign sgn = (char_i == nlv_pkg::CH_PLUS) || (char_i == nlv_pkg::CH_MINUS);
  assign cnt_inc = (st_r.count == nlv_pkg::COUNT_MAX) ? st_r.count
                                                      : st_r.count + 1'b1;

  // character update
  always_comb begin
    ch_st = st_r;
    if (char_i == nlv_pkg::CH_NUL) begin
      ch_st.stopped = 1'b1;
    end else if (fmt_i == nlv_pkg::FMT_INT) begin
      if (st_r.phase == nlv_pkg::PH_START && sgn) begin
        ch_st.phase = nlv_pkg::PH_INT_PART;
      end else if ((st_r.phase == nlv_pkg::PH_START ||
                    st_r.phase == nlv_pkg::PH_INT_PART) && dig) begin
        ch_st.phase     = nlv_pkg::PH_INT_PART;
        ch_st.mant_seen = 1'b1;
        ch_st.count     = cnt_inc;
      end else begin
        ch_st.err = nlv_pkg::ST_BAD_SYM;
      end
    end else begin
      unique case (st_r.phase)
        nlv_pkg::PH_START, nlv_pkg::PH_INT_PART: begin
          if (sgn && st_r.phase == nlv_pkg::PH_START) begin
            ch_st.phase = nlv_pkg::PH_INT_PART;
          end else if (dig) begin
            ch_st.phase     = nlv_pkg::PH_INT_PART;
            ch_st.mant_seen = 1'b1;
            ch_st.count     = cnt_inc;
          end else if (char_i == nlv_pkg::CH_POINT) begin
            ch_st.phase = nlv_pkg::PH_FRACTION;
          end else if (char_i == nlv_pkg::CH_E && st_r.mant_seen) begin
            ch_st.phase = nlv_pkg::PH_EXP_MARK;
          end else begin
            ch_st.err = nlv_pkg::ST_BAD_REAL;
          end
        end
        nlv_pkg::PH_FRACTION: begin
          if (dig) begin
            ch_st.mant_seen = 1'b1;
            ch_st.count     = cnt_inc;
          end else if (char_i == nlv_pkg::CH_E && st_r.mant_seen) begin
            ch_st.phase = nlv_pkg::PH_EXP_MARK;
          end else begin
            ch_st.err = nlv_pkg::ST_BAD_REAL;
          end
        end
        nlv_pkg::PH_EXP_MARK: begin
          if (sgn) begin
            ch_st.phase = nlv_pkg::PH_EXP_SIGN;
          end else if (dig) begin
            ch_st.phase    = nlv_pkg::PH_EXP_DIGS;
            ch_st.exp_seen = 1'b1;
          end else begin
            ch_st.err = nlv_pkg::ST_BAD_REAL;
          end
        end
        nlv_pkg::PH_EXP_SIGN, nlv_pkg::PH_EXP_DIGS: begin
          if (dig) begin
            ch_st.phase    = nlv_pkg::PH_EXP_DIGS;
            ch_st.exp_seen = 1'b1;
          end else begin
            ch_st.err = nlv_pkg::ST_BAD_REAL;
          end
        end
        default: begin
          ch_st.err = nlv_pkg::ST_BAD_REAL;
        end
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (step) begin
      if (end_i) begin
        st_nxt = nlv_pkg::STATE_CLEAR;
      end else if (!st_r.stopped && st_r.err == nlv_pkg::ST_OK) begin
        st_nxt = ch_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= nlv_pkg::STATE_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  // verdict on the state before the end beat
  assign too_many = st_r.count > {{(nlv_pkg::COUNT_W - nlv_pkg::MAXD_W){1'b0}}, max_digits_i};

  always_comb begin
    st_code = too_many ? nlv_pkg::ST_TOO_MANY : nlv_pkg::ST_OK;
    if (fmt_i == nlv_pkg::FMT_INT) begin
      if (st_r.err != nlv_pkg::ST_OK ||
          !(st_r.phase == nlv_pkg::PH_START || st_r.phase == nlv_pkg::PH_INT_PART)) begin
        st_code = nlv_pkg::ST_BAD_SYM;
      end else if (!st_r.mant_seen) begin
        st_code = nlv_pkg::ST_NO_DIGITS;
      end
    end else begin
      if (st_r.err != nlv_pkg::ST_OK || !st_r.mant_seen) begin
        st_code = nlv_pkg::ST_BAD_REAL;
      end else if (!(st_r.phase == nlv_pkg::PH_START ||
                     st_r.phase == nlv_pkg::PH_INT_PART ||
                     st_r.phase == nlv_pkg::PH_FRACTION ||
                     st_r.phase == nlv_pkg::PH_EXP_DIGS)) begin
        st_code = nlv_pkg::ST_BAD_REAL;
      end else if (st_r.phase == nlv_pkg::PH_EXP_DIGS && !st_r.exp_seen) begin
        st_code = nlv_pkg::ST_BAD_REAL;
      end
    end
  end

  assign verdict_o.status = st_code;
  assign verdict_o.count  = (st_code == nlv_pkg::ST_OK || st_code == nlv_pkg::ST_TOO_MANY)
                            ? st_r.count : '0;

endmodule

FILE: sv/nlv_out_reg.sv
// Result register driving the master-side stream.
module nlv_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  nlv_pkg::verdict_t           verdict_i,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [nlv_pkg::OUT_W-1:0]   out_tdata,
  output logic                        free
);

  logic              valid_r;
  logic              valid_nxt;
  nlv_pkg::verdict_t data_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= verdict_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(nlv_pkg::OUT_W - nlv_pkg::STATUS_W - nlv_pkg::COUNT_W){1'b0}},
                       data_r.count, data_r.status};

endmodule

FILE: sv/numeric_literal_validator.sv
// Numeric literal validator top level: input register, parser, result register.
//
//   channel  dir  handshake          payload
//   in_      in   in_tvalid/tready   tdata char_code, tlast end_of_string
//   out_     out  out_tvalid/tready  tdata status, digit_count
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One beat per cycle sustained while the output is not stalled; a character beat is
// registered, then folded into the parse state in the following cycle. An end beat
// is loaded into the result register once that register is free, and is held until taken.
// Reset is synchronous: parse state clears, number_format 0, max_digits 40.
// A stalled output holds an end beat in the input register and drops in_tready;
// the beats behind it wait until the end beat moves on.
module numeric_literal_validator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nlv_pkg::CHAR_W-1:0]        in_tdata,   // [7:0] char_code
  input  logic                              in_tlast,   // end_of_string
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nlv_pkg::OUT_W-1:0]         out_tdata,  // [2:0] status, [12:3] digit_count
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [nlv_pkg::MAXD_W-1:0]        cfg_wdata
);

  nlv_pkg::fmt_t               fmt_r;
  logic [nlv_pkg::MAXD_W-1:0]  max_digits_r;
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic [nlv_pkg::CHAR_W-1:0]  s1_char_r;
  logic                        s1_end_r;
  logic                        s1_fire;
  logic                        out_free;
  logic                        in_fire;
  nlv_pkg::verdict_t           verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= nlv_pkg::FMT_REAL;
      max_digits_r <= 8'd40;
    end else if (cfg_we) begin
      unique case (nlv_pkg::cfg_idx_t'(cfg_index))
        nlv_pkg::CFG_NUMBER_FORMAT: fmt_r <= nlv_pkg::fmt_t'(cfg_wdata[0]);
        nlv_pkg::CFG_MAX_DIGITS:    max_digits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_fire   = s1_valid_r && (!s1_end_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  nlv_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_fire),
    .end_i        (s1_end_r),
    .char_i       (s1_char_r),
    .fmt_i        (fmt_r),
    .max_digits_i (max_digits_r),
    .verdict_o    (verdict)
  );

  nlv_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_fire && s1_end_r),
    .verdict_i  (verdict),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .free       (out_free)
  );

`ifndef SYNTHESIS
  a_end_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_end_r |=> out_tvalid)
    else $error("end beat did not produce a result");

  a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(s1_fire && s1_end_r) |=> !out_tvalid)
    else $error("result appeared without an end beat");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_char_r) && $stable(s1_end_r))
    else $error("input stage lost a held beat");

  a_error_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == nlv_pkg::ST_BAD_REAL ||
                   out_tdata[2:0] == nlv_pkg::ST_NO_DIGITS ||
                   out_tdata[2:0] == nlv_pkg::ST_BAD_SYM) |-> out_tdata[12:3] == '0)
    else $error("digit count reported with a syntax error");
`endif

endmodule
